// ===== hw/rtl/swls_pkg.sv =====
// ----------------------------------------------------------------------------
// swls_pkg
// Shared types and constants of the sliding window latency statistics unit.
// ----------------------------------------------------------------------------
package swls_pkg;

    // request kinds
    localparam logic REQ_EVENT  = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // register indexes, taken from address bit 2
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_SLOW_THRESH = 1'b1;

    localparam logic [8:0]  WINDOW_SIZE_RST = 9'd256;
    localparam logic [31:0] SLOW_THRESH_RST = 32'd1000000;
    localparam int unsigned MIN_WINDOW      = 10;

    // percentile as a ratio of integers
    localparam int unsigned P95_NUM = 95;
    localparam int unsigned P95_DEN = 100;

    // floor(95*m/100) as (m*P95_RECIP) >> P95_SHIFT, exact for 95*m below 2^20
    localparam int unsigned P95_RECIP = 63753455;
    localparam int unsigned P95_SHIFT = 26;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        req_type;
        logic        event_failed;
        logic [31:0] edge_lat_ns;
        logic [31:0] event_duration_ns;
    } in_item_t;

    typedef struct packed {
        logic [31:0] incoming_in_period;
        logic [31:0] pulses_in_period;
        logic [31:0] errors_in_period;
        logic [31:0] slow_in_period;
        logic [8:0]  sample_count;
        logic [31:0] min_latency_ns;
        logic [31:0] avg_latency_ns;
        logic [31:0] p95_latency_ns;
        logic [31:0] max_latency_ns;
    } out_item_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_STAT  = 7'b0000010,
        S_KDIV  = 7'b0000100,
        S_SEL   = 7'b0001000,
        S_CWAIT = 7'b0010000,
        S_SWEEP = 7'b0100000,
        S_AVG   = 7'b1000000
    } state_t;

    // saturating increment of a period counter
    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

endpackage

// ===== hw/rtl/swls_div.sv =====
// ----------------------------------------------------------------------------
// swls_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module swls_div #(
    parameter int NW = 48,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [DW:0]     trial;
    logic            qbit;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        qbit     = (trial >= {1'b0, den_reg});
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            cnt_next = CNTW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], qbit};
            cnt_next  = cnt_reg - CNTW'(1);
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/sliding_window_latency_stats_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_latency_stats_unit
// Period counters and sliding-window latency statistics of trigger events.
// ----------------------------------------------------------------------------
// An event transaction bumps the period counters and writes its latency
// into the window memory. A report transaction walks the window memory
// through its read ports: a pass for min, max and sum, a step for the
// percentile rank (a reciprocal multiply), then a rank search that scans
// the whole window once per candidate sample, and a final divide for the
// rounded mean, where the divider width NW is LATENCY_BITS plus the count
// width plus one. The input is held off while a report is in progress, and
// a report is held off while the previous result still waits at the
// output; events keep flowing.
// ----------------------------------------------------------------------------
module sliding_window_latency_stats_unit #(
    parameter int WINDOW_DEPTH = 256,
    parameter int LATENCY_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  swls_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output swls_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = (CW > 9) ? CW : 9;
    localparam int EW    = (LATENCY_BITS > 32) ? LATENCY_BITS : 32;
    localparam int SUM_W = LATENCY_BITS + CW;
    localparam int NW    = SUM_W + 1;
    localparam int DW    = CW + 1;
    localparam int KMW   = CW + swls_pkg::P95_SHIFT;

    // index into the window, wrapped at the memory depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(WINDOW_DEPTH))
        begin
            s = s - (CW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [31:0] to32(input logic [LATENCY_BITS-1:0] v);
        logic [EW-1:0] t;
        t = EW'(v);
        return t[31:0];
    endfunction

    // registers
    logic [8:0]              window_size_reg;
    logic [31:0]             slow_thresh_reg;
    swls_pkg::state_t        state_reg, state_next;
    logic [AW-1:0]           oldest_reg;
    logic [CW-1:0]           fill_reg;
    logic [31:0]             incoming_reg, pulse_reg, error_reg, slow_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           iss_reg, iss_next;
    logic                    pend_reg, pend_next;
    logic [CW-1:0]           cand_reg, cand_next;
    logic [CW:0]             less_reg, less_next, eq_reg, eq_next;
    logic [CW-1:0]           k_reg;
    logic [LATENCY_BITS-1:0] min_reg, max_reg, p95_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    out_valid_reg;
    swls_pkg::out_item_t     out_data_reg;

    // window memory
    logic [LATENCY_BITS-1:0] mem [WINDOW_DEPTH];
    logic [LATENCY_BITS-1:0] rda_reg, rdb_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [LATENCY_BITS-1:0] mem_wd;
    logic                    rda_en, rdb_en;
    logic [AW-1:0]           rda_addr, rdb_addr;

    // decode of the accepted transaction
    logic                    in_fire, ev_fire, rep_fire, cfg_we;
    logic [SW-1:0]           eff_size;
    logic                    win_full;
    logic [EW-1:0]           lat_ext;
    logic [LATENCY_BITS-1:0] lat_sat;

    // divider
    logic                    div_start, div_done;
    logic [NW-1:0]           div_num, div_quo;
    logic [DW-1:0]           div_den;
    logic [KMW-1:0]          k_mul;
    logic                    found;
    logic                    finish;

    assign in_ready = (state_reg == swls_pkg::S_IDLE) &&
                      !(out_valid_reg && (in_data.req_type == swls_pkg::REQ_REPORT));
    assign in_fire  = in_valid && in_ready;
    assign ev_fire  = in_fire && (in_data.req_type == swls_pkg::REQ_EVENT);
    assign rep_fire = in_fire && (in_data.req_type == swls_pkg::REQ_REPORT);
    assign cfg_we   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // register read back
    always_comb
    begin
        case (paddr[2])
            swls_pkg::CFG_WINDOW_SIZE: prdata = {23'd0, window_size_reg};
            swls_pkg::CFG_SLOW_THRESH: prdata = slow_thresh_reg;
            default:                   prdata = '0;
        endcase
    end

    // effective window size clamped to the legal range
    always_comb
    begin
        eff_size = SW'(window_size_reg);
        if (eff_size < SW'(swls_pkg::MIN_WINDOW))
        begin
            eff_size = SW'(swls_pkg::MIN_WINDOW);
        end
        if (eff_size > SW'(WINDOW_DEPTH))
        begin
            eff_size = SW'(WINDOW_DEPTH);
        end
        win_full = (SW'(fill_reg) >= eff_size);
    end

    // latency saturation to the stored width
    always_comb
    begin
        lat_ext = EW'(in_data.edge_lat_ns);
        lat_sat = (lat_ext > EW'({LATENCY_BITS{1'b1}})) ? {LATENCY_BITS{1'b1}}
                                                         : lat_ext[LATENCY_BITS-1:0];
    end

    assign mem_we = ev_fire && !in_data.event_failed;
    assign mem_wa = wrap_add(oldest_reg, fill_reg);
    assign mem_wd = lat_sat;

    // memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rda_en)
        begin
            rda_reg <= mem[rda_addr];
        end
        if (rdb_en)
        begin
            rdb_reg <= mem[rdb_addr];
        end
    end

    // rank of the percentile sample by reciprocal multiply, and the found test
    assign k_mul = KMW'(n_reg - CW'(1)) * KMW'(swls_pkg::P95_RECIP);
    assign found = (less_reg <= (CW+1)'(k_reg)) &&
                   ((CW+1)'(k_reg) < (less_reg + eq_reg));

    // report sequencer
    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        pend_next  = 1'b0;
        cand_next  = cand_reg;
        less_next  = less_reg;
        eq_next    = eq_reg;
        rda_en     = 1'b0;
        rda_addr   = wrap_add(oldest_reg, cand_reg);
        rdb_en     = 1'b0;
        rdb_addr   = wrap_add(oldest_reg, iss_reg);
        div_start  = 1'b0;
        div_num    = NW'({sum_reg, 1'b0}) + NW'(n_reg);
        div_den    = DW'({n_reg, 1'b0});
        finish     = 1'b0;
        case (state_reg)
            swls_pkg::S_IDLE:
            begin
                iss_next = '0;
                if (rep_fire && (fill_reg != '0))
                begin
                    state_next = swls_pkg::S_STAT;
                end
            end
            swls_pkg::S_STAT:
            begin
                if (iss_reg != n_reg)
                begin
                    rdb_en    = 1'b1;
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = swls_pkg::S_KDIV;
                end
            end
            swls_pkg::S_KDIV:
            begin
                cand_next  = '0;
                state_next = swls_pkg::S_SEL;
            end
            swls_pkg::S_SEL:
            begin
                rda_en     = 1'b1;
                state_next = swls_pkg::S_CWAIT;
            end
            swls_pkg::S_CWAIT:
            begin
                iss_next   = '0;
                less_next  = '0;
                eq_next    = '0;
                state_next = swls_pkg::S_SWEEP;
            end
            swls_pkg::S_SWEEP:
            begin
                if (pend_reg)
                begin
                    if (rdb_reg < rda_reg)
                    begin
                        less_next = less_reg + (CW+1)'(1);
                    end
                    if (rdb_reg == rda_reg)
                    begin
                        eq_next = eq_reg + (CW+1)'(1);
                    end
                end
                if (iss_reg != n_reg)
                begin
                    rdb_en    = 1'b1;
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (found)
                    begin
                        div_start  = 1'b1;
                        state_next = swls_pkg::S_AVG;
                    end
                    else
                    begin
                        cand_next  = cand_reg + CW'(1);
                        state_next = swls_pkg::S_SEL;
                    end
                end
            end
            swls_pkg::S_AVG:
            begin
                if (div_done)
                begin
                    finish     = 1'b1;
                    state_next = swls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = swls_pkg::S_IDLE;
            end
        endcase
    end

    // divider for the rounded mean
    swls_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // control state, window pointers, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= swls_pkg::S_IDLE;
            window_size_reg <= swls_pkg::WINDOW_SIZE_RST;
            slow_thresh_reg <= swls_pkg::SLOW_THRESH_RST;
            oldest_reg      <= '0;
            fill_reg        <= '0;
            incoming_reg    <= '0;
            pulse_reg       <= '0;
            error_reg       <= '0;
            slow_reg        <= '0;
            iss_reg         <= '0;
            pend_reg        <= 1'b0;
            cand_reg        <= '0;
            less_reg        <= '0;
            eq_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
            cand_reg  <= cand_next;
            less_reg  <= less_next;
            eq_reg    <= eq_next;

            if (cfg_we)
            begin
                case (paddr[2])
                    swls_pkg::CFG_WINDOW_SIZE: window_size_reg <= pwdata[8:0];
                    swls_pkg::CFG_SLOW_THRESH: slow_thresh_reg <= pwdata;
                    default:                   window_size_reg <= window_size_reg;
                endcase
            end

            // event transaction
            if (ev_fire)
            begin
                incoming_reg <= swls_pkg::sat_inc(incoming_reg);
                if (in_data.event_failed)
                begin
                    error_reg <= swls_pkg::sat_inc(error_reg);
                end
                else
                begin
                    pulse_reg <= swls_pkg::sat_inc(pulse_reg);
                    if (in_data.event_duration_ns > slow_thresh_reg)
                    begin
                        slow_reg <= swls_pkg::sat_inc(slow_reg);
                    end
                    if (win_full)
                    begin
                        oldest_reg <= wrap_add(oldest_reg, CW'(1));
                    end
                    else
                    begin
                        fill_reg <= fill_reg + CW'(1);
                    end
                end
            end

            // report transaction clears the period counters
            if (rep_fire)
            begin
                incoming_reg <= '0;
                pulse_reg    <= '0;
                error_reg    <= '0;
                slow_reg     <= '0;
            end

            // output register
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((rep_fire && (fill_reg == '0)) || finish)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // report datapath
    always_ff @(posedge clk)
    begin
        if (rep_fire)
        begin
            n_reg                           <= fill_reg;
            min_reg                         <= {LATENCY_BITS{1'b1}};
            max_reg                         <= '0;
            sum_reg                         <= '0;
            out_data_reg.incoming_in_period <= incoming_reg;
            out_data_reg.pulses_in_period   <= pulse_reg;
            out_data_reg.errors_in_period   <= error_reg;
            out_data_reg.slow_in_period     <= slow_reg;
            out_data_reg.sample_count       <= 9'(SW'(fill_reg));
            out_data_reg.min_latency_ns     <= '0;
            out_data_reg.avg_latency_ns     <= '0;
            out_data_reg.p95_latency_ns     <= '0;
            out_data_reg.max_latency_ns     <= '0;
        end
        if ((state_reg == swls_pkg::S_STAT) && pend_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rdb_reg);
            if (rdb_reg < min_reg)
            begin
                min_reg <= rdb_reg;
            end
            if (rdb_reg > max_reg)
            begin
                max_reg <= rdb_reg;
            end
        end
        if (state_reg == swls_pkg::S_KDIV)
        begin
            k_reg <= k_mul[swls_pkg::P95_SHIFT +: CW];
        end
        if (div_start && (state_reg == swls_pkg::S_SWEEP))
        begin
            p95_reg <= rda_reg;
        end
        if (finish)
        begin
            out_data_reg.min_latency_ns <= to32(min_reg);
            out_data_reg.max_latency_ns <= to32(max_reg);
            out_data_reg.p95_latency_ns <= to32(p95_reg);
            out_data_reg.avg_latency_ns <= to32(div_quo[LATENCY_BITS-1:0]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_window_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != swls_pkg::S_IDLE) |=> $stable(oldest_reg) && $stable(fill_reg))
        else $error("window moved during a report");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !out_valid_reg)
        else $error("report finished over a pending result");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == swls_pkg::S_AVG))
        else $error("divider result outside the mean step");

endmodule
